// File: sv/rbf_pkg.sv
// ----------------------------------------------------------------------------
// RGB box filter package
// Shared types and constants for the 3x3 RGB mean filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbf_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 12;
  localparam int ROW_BITS        = 12;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int MIN_SIZE     = 3;
  localparam int MAX_HEIGHT   = 4095;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // Division by nine as a multiplication by a rounded-up reciprocal.
  // Exact for every sum of nine 8-bit values.
  localparam int SUM_BITS    = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_BITS  = 13;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP_9 = RECIP_BITS'((1 << RECIP_SHIFT) / 9 + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_entry_t;

endpackage

// File: sv/rgb_box_filter_3x3.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter
// Streaming 3x3 mean filter on RGB pixels in raster order. The block takes
// one transaction per clock and sustains that rate: a pixel or flush enters
// every cycle unless the result side stalls with no free pipeline stage. A
// result passes stages 1, 2 and 3 and then the result register; the filter
// itself lags the input by one line plus one pixel, so the first width + 1
// pixels after reset or after a full drain give no result. Each channel of an
// interior pixel is the truncated mean of its nine neighbors; pixels on the
// first and last row and column are copied. Flush transactions push blank
// pixels to drain the pending results at the end of a frame. Both line stores
// share one memory of MAX_WIDTH entries with one registered read per cycle;
// a read of the column written in the same cycle is forwarded. The memory has
// no clearing pass and needs none. Width and height must be written over the
// register port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_box_filter_3x3
  import rbf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic        action,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,

  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        last_pixel,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  logic [CFG_WIDTH_BITS-1:0]  image_width;
  logic [CFG_HEIGHT_BITS-1:0] image_height;
  logic [WW-1:0]              eff_w;
  logic [ROW_BITS-1:0]        eff_h;

  logic [AW-1:0]       in_col;
  logic [ROW_BITS-1:0] in_row;
  logic [AW-1:0]       out_col;
  logic [ROW_BITS-1:0] out_row;
  logic [PW-1:0]       pending;

  logic [AW-1:0]       in_col_next;
  logic [ROW_BITS-1:0] in_row_next;
  logic [AW-1:0]       out_col_next;
  logic [ROW_BITS-1:0] out_row_next;
  logic [PW-1:0]       pending_next;

  logic [WW-1:0]       in_col_inc;
  logic [WW-1:0]       out_col_inc;
  logic [ROW_BITS:0]   in_row_inc;
  logic [ROW_BITS:0]   out_row_inc;
  logic                in_col_end;
  logic                out_col_end;
  logic                in_row_end;
  logic                out_row_end;
  logic [PW-1:0]       w_plus1;

  logic pix_acc;
  logic is_flush;
  logic has_pending;
  logic do_push;
  logic do_emit;
  logic drain_done;
  logic emit_interior;
  logic emit_last;

  logic load_1;
  logic load_2;
  logic load_3;
  logic load_o;
  logic consume_1;

  line_entry_t line_mem [MAX_WIDTH];
  line_entry_t rd_q;

  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  rgb_t          s1_pix;
  logic          s1_emit;
  logic          s1_interior;
  logic          s1_last;
  logic          s1_fwd;
  rgb_t          fwd_top;
  rgb_t          fwd_mid;
  rgb_t          top_eff;
  rgb_t          mid_eff;

  rgb_t win [9];
  logic s2_valid;
  logic s2_interior;
  logic s2_last;

  logic [SUM_BITS-1:0] sum_r;
  logic [SUM_BITS-1:0] sum_g;
  logic [SUM_BITS-1:0] sum_b;

  logic                s3_valid;
  logic [SUM_BITS-1:0] s3_sum_r;
  logic [SUM_BITS-1:0] s3_sum_g;
  logic [SUM_BITS-1:0] s3_sum_b;
  rgb_t                s3_centre;
  logic                s3_interior;
  logic                s3_last;

  logic [PROD_BITS-1:0] prod_r;
  logic [PROD_BITS-1:0] prod_g;
  logic [PROD_BITS-1:0] prod_b;

  // Register port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_BITS'(WIDTH_RESET);
      image_height <= CFG_HEIGHT_BITS'(HEIGHT_RESET);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_IDX_WIDTH:  image_width  <= pwdata[CFG_WIDTH_BITS-1:0];
        REG_IDX_HEIGHT: image_height <= pwdata[CFG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDX_WIDTH:  prdata = 32'(image_width);
      REG_IDX_HEIGHT: prdata = 32'(image_height);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width < CFG_WIDTH_BITS'(MIN_SIZE)) begin
      eff_w = WW'(MIN_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height < CFG_HEIGHT_BITS'(MIN_SIZE)) begin
      eff_h = ROW_BITS'(MIN_SIZE);
    end else begin
      eff_h = ROW_BITS'(image_height);
    end
  end

  // Pipeline enables, from the result register back to the input.
  assign load_o      = !result_valid || !result_stall;
  assign load_3      = !s3_valid || load_o;
  assign load_2      = !s2_valid || load_3;
  assign load_1      = !s1_valid || load_2;
  assign consume_1   = s1_valid && load_2;
  assign pixel_stall = !load_1;

  // Transaction decode and position counters.
  assign pix_acc     = pixel_valid && !pixel_stall;
  assign is_flush    = (action == ACTION_FLUSH);
  assign has_pending = (pending != '0);
  assign w_plus1     = PW'(eff_w) + PW'(1);
  assign do_push     = pix_acc && (!is_flush || has_pending);
  assign do_emit     = pix_acc && (is_flush ? has_pending : (pending >= w_plus1));
  assign drain_done  = pix_acc && is_flush && (pending == PW'(1));

  assign in_col_inc  = WW'(in_col) + WW'(1);
  assign out_col_inc = WW'(out_col) + WW'(1);
  assign in_row_inc  = {1'b0, in_row} + (ROW_BITS+1)'(1);
  assign out_row_inc = {1'b0, out_row} + (ROW_BITS+1)'(1);
  assign in_col_end  = (in_col_inc >= eff_w);
  assign out_col_end = (out_col_inc >= eff_w);
  assign in_row_end  = (in_row_inc >= {1'b0, eff_h});
  assign out_row_end = (out_row_inc >= {1'b0, eff_h});

  assign emit_interior = (out_row != '0) && !out_row_end && (out_col != '0) && !out_col_end;
  assign emit_last     = out_row_end && out_col_end;

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pending_next = pending;
    if (do_push) begin
      if (in_col_end) begin
        in_col_next = '0;
        in_row_next = in_row_end ? '0 : in_row_inc[ROW_BITS-1:0];
      end else begin
        in_col_next = in_col_inc[AW-1:0];
      end
    end
    if (drain_done) begin
      in_col_next = '0;
      in_row_next = '0;
    end
    if (do_emit) begin
      if (out_col_end) begin
        out_col_next = '0;
        out_row_next = out_row_end ? '0 : out_row_inc[ROW_BITS-1:0];
      end else begin
        out_col_next = out_col_inc[AW-1:0];
      end
    end
    if (pix_acc) begin
      if (is_flush && has_pending) begin
        pending_next = pending - PW'(1);
      end else if (!is_flush && !(pending >= w_plus1)) begin
        pending_next = pending + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      pending <= pending_next;
    end
  end

  // Line store memory: upper and middle lines side by side.
  always_ff @(posedge clk) begin
    if (consume_1) begin
      line_mem[s1_addr] <= '{upper: mid_eff, middle: s1_pix};
    end
    if (do_push) begin
      rd_q <= line_mem[in_col];
    end
  end

  // Stage 1: line store data returns; forward the entry written in the same cycle.
  assign top_eff = s1_fwd ? fwd_top : rd_q.upper;
  assign mid_eff = s1_fwd ? fwd_mid : rd_q.middle;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load_1) begin
      s1_valid <= do_push;
    end
  end

  always_ff @(posedge clk) begin
    if (load_1) begin
      s1_addr     <= in_col;
      s1_pix      <= is_flush ? '0 : rgb_t'{red: red_in, green: green_in, blue: blue_in};
      s1_emit     <= do_emit;
      s1_interior <= emit_interior;
      s1_last     <= emit_last;
      s1_fwd      <= s1_valid && (s1_addr == in_col);
    end
    if (consume_1) begin
      fwd_top <= mid_eff;
      fwd_mid <= s1_pix;
    end
  end

  // Stage 2: the window shifts one column.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
      s2_valid <= 1'b0;
    end else if (load_2) begin
      s2_valid <= consume_1 && s1_emit;
      if (consume_1) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= top_eff;
        win[5] <= mid_eff;
        win[8] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_2) begin
      s2_interior <= s1_interior;
      s2_last     <= s1_last;
    end
  end

  // Stage 3: channel sums over the window.
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 9; k++) begin
      sum_r = sum_r + SUM_BITS'(win[k].red);
      sum_g = sum_g + SUM_BITS'(win[k].green);
      sum_b = sum_b + SUM_BITS'(win[k].blue);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (load_3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_3) begin
      s3_sum_r    <= sum_r;
      s3_sum_g    <= sum_g;
      s3_sum_b    <= sum_b;
      s3_centre   <= win[4];
      s3_interior <= s2_interior;
      s3_last     <= s2_last;
    end
  end

  // Result register: divide by nine or copy the centre.
  assign prod_r = PROD_BITS'(s3_sum_r) * PROD_BITS'(RECIP_9);
  assign prod_g = PROD_BITS'(s3_sum_g) * PROD_BITS'(RECIP_9);
  assign prod_b = PROD_BITS'(s3_sum_b) * PROD_BITS'(RECIP_9);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_o) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o && s3_valid) begin
      red_out    <= s3_interior ? prod_r[RECIP_SHIFT +: 8] : s3_centre.red;
      green_out  <= s3_interior ? prod_g[RECIP_SHIFT +: 8] : s3_centre.green;
      blue_out   <= s3_interior ? prod_b[RECIP_SHIFT +: 8] : s3_centre.blue;
      last_pixel <= s3_last;
    end
  end

endmodule

// File: sv/rbf_checker.sv
// ----------------------------------------------------------------------------
// RGB box filter checker
// Port-level assertions for the 3x3 RGB mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic        last_pixel,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(red_out) && $stable(green_out) &&
                                     $stable(blue_out) && $stable(last_pixel))
    else $error("stalled result payload changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !pixel_stall)
    else $error("input stalled while the result register is empty");

  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 (!paddr[2])
      |-> prdata[10:0] == $past(pwdata[10:0]))
    else $error("width register does not read back the written value");

endmodule

bind rgb_box_filter_3x3 rbf_checker u_rbf_checker (.*);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter testbench
// Streams whole and truncated frames of random RGB pixels and flushes into the
// filter, predicts every filtered or copied output pixel with a model of the
// line stores and the 3x3 window kept inside the bench, and checks each result
// in order. Frame sizes are set over the register port between runs, from the
// smallest frame up to medium ones, including clamped register values.
// Both handshakes idle and stall at random in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rbf_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEFAULT;
  localparam int NEIGHBORS = 9;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 160;
  localparam logic [2:0] ADDR_WIDTH = {REG_IDX_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_IDX_HEIGHT, 2'b00};

  typedef struct packed {
    logic act;
    rgb_t px;
  } pixel_item_t;

  typedef struct packed {
    rgb_t px;
    logic last;
  } box_result_t;

  logic clk;
  logic rst = 1'b1;

  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic action = ACTION_PIXEL;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;

  logic result_valid;
  logic result_stall = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic last_pixel;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rgb_box_filter_3x3 u_top (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .action(action),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .last_pixel(last_pixel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Filter state as the bench sees it.
  rgb_t upper_line [MAX_W];
  rgb_t middle_line [MAX_W];
  rgb_t win_px [NEIGHBORS];
  int unsigned wr_col = 0;
  int unsigned wr_row = 0;
  int unsigned rd_col = 0;
  int unsigned rd_row = 0;
  int unsigned backlog = 0;
  logic [CFG_WIDTH_BITS-1:0] width_reg = CFG_WIDTH_BITS'(WIDTH_RESET);
  logic [CFG_HEIGHT_BITS-1:0] height_reg = CFG_HEIGHT_BITS'(HEIGHT_RESET);

  pixel_item_t pixel_queue [$];
  box_result_t expected_pixels [$];
  pixel_item_t cur_item;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned useful_items = 0;
  int unsigned results_seen = 0;
  int unsigned settings = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic int unsigned used_width();
    if (width_reg < MIN_SIZE) return MIN_SIZE;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (height_reg < MIN_SIZE) return MIN_SIZE;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void step_position(inout int unsigned col, inout int unsigned row);
    if (col + 1 >= used_width()) begin
      col = 0;
      row = (row + 1 >= used_height()) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function automatic void shift_window(rgb_t px);
    rgb_t top;
    rgb_t mid;
    top = upper_line[wr_col];
    mid = middle_line[wr_col];
    upper_line[wr_col] = mid;
    middle_line[wr_col] = px;
    for (int r = 0; r < 3; r++) begin
      win_px[3*r] = win_px[3*r+1];
      win_px[3*r+1] = win_px[3*r+2];
    end
    win_px[2] = top;
    win_px[5] = mid;
    win_px[8] = px;
    step_position(wr_col, wr_row);
  endfunction

  function automatic box_result_t mean_output();
    box_result_t res;
    int unsigned w;
    int unsigned h;
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    bit interior;
    w = used_width();
    h = used_height();
    interior = rd_row >= 1 && rd_row + 1 < h && rd_col >= 1 && rd_col + 1 < w;
    if (interior) begin
      sr = 0;
      sg = 0;
      sb = 0;
      for (int k = 0; k < NEIGHBORS; k++) begin
        sr += win_px[k].red;
        sg += win_px[k].green;
        sb += win_px[k].blue;
      end
      res.px.red = 8'(sr / NEIGHBORS);
      res.px.green = 8'(sg / NEIGHBORS);
      res.px.blue = 8'(sb / NEIGHBORS);
    end else begin
      res.px = win_px[4];
    end
    res.last = rd_row + 1 >= h && rd_col + 1 >= w;
    step_position(rd_col, rd_row);
    return res;
  endfunction

  // Returns 1 when the transaction releases an output pixel.
  function automatic bit box_filter_step(input pixel_item_t it, output box_result_t res);
    res = '0;
    if (it.act == ACTION_PIXEL) begin
      shift_window(it.px);
      if (backlog >= used_width() + 1) begin
        res = mean_output();
        return 1'b1;
      end
      backlog++;
      return 1'b0;
    end
    if (backlog == 0) return 1'b0;
    shift_window('0);
    res = mean_output();
    backlog--;
    if (backlog == 0) begin
      wr_col = 0;
      wr_row = 0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] random_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t px;
    px.red = random_channel();
    px.green = random_channel();
    px.blue = random_channel();
    return px;
  endfunction

  task automatic queue_item(input logic act, input rgb_t px, input bit counts);
    pixel_item_t it;
    it.act = act;
    it.px = px;
    pixel_queue.push_back(it);
    items_queued++;
    if (counts) useful_items++;
  endtask

  task automatic queue_pixels(input int unsigned n);
    repeat (n) queue_item(ACTION_PIXEL, random_pixel(), 1'b1);
  endtask

  task automatic queue_drain();
    repeat (used_width() + 1) queue_item(ACTION_FLUSH, random_pixel(), 1'b1);
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int unsigned w_raw, input int unsigned h_raw);
    write_reg(ADDR_WIDTH, 32'(w_raw));
    write_reg(ADDR_HEIGHT, 32'(h_raw));
    width_reg = CFG_WIDTH_BITS'(w_raw);
    height_reg = CFG_HEIGHT_BITS'(h_raw);
    settings++;
  endtask

  // One stretch of stream at the current frame size, always ending drained
  // with the output position back at the top left corner.
  task automatic queue_run();
    int unsigned frame;
    int unsigned part;
    int unsigned frames;
    frame = used_width() * used_height();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        frames = $urandom_range(1, 2);
        queue_pixels(frame);
        if (frames > 1) begin
          if ($urandom_range(1) == 1) wait_drained();
          queue_pixels(frame);
        end
        queue_drain();
      end
      4, 5: begin
        // A truncated frame, then the remainder as a frame of its own.
        part = $urandom_range(used_width() + 1, frame - used_width() - 1);
        queue_pixels(part);
        queue_drain();
        queue_pixels(frame - part);
        queue_drain();
      end
      6: begin
        queue_pixels(frame);
        queue_drain();
        repeat ($urandom_range(1, 3)) queue_item(ACTION_FLUSH, random_pixel(), 1'b0);
      end
      default: begin
        queue_pixels(frame);
        queue_drain();
      end
    endcase
  endtask

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin : drive_pixels
    box_result_t predicted;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (box_filter_step(cur_item, predicted)) expected_pixels.push_back(predicted);
        items_taken++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pixel_queue.pop_front();
          pixel_valid <= 1'b1;
          action <= cur_item.act;
          red_in <= cur_item.px.red;
          green_in <= cur_item.px.green;
          blue_in <= cur_item.px.blue;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    box_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          log_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0d",
                                 red_out, green_out, blue_out, last_pixel));
        end else begin
          want = expected_pixels.pop_front();
          if (red_out !== want.px.red || green_out !== want.px.green ||
              blue_out !== want.px.blue || last_pixel !== want.last) begin
            log_mismatch($sformatf(
              "expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
              want.px.red, want.px.green, want.px.blue, want.last,
              red_out, green_out, blue_out, last_pixel));
          end
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int unsigned phase_start;
    int unsigned w_raw;
    int unsigned h_raw;
    rgb_t px;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int k = 0; k < NEIGHBORS; k++) win_px[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame through clamped register values, with flushes on an
    // empty pipeline before and after.
    configure(0, 2);
    queue_item(ACTION_FLUSH, 24'hffffff, 1'b1);
    for (int i = 0; i < 9; i++) begin
      px.red = (i % 2 == 1) ? 8'hff : 8'h00;
      px.green = (i % 3 == 0) ? 8'hff : 8'h00;
      px.blue = 8'(i * 31);
      queue_item(ACTION_PIXEL, px, 1'b1);
    end
    queue_drain();
    queue_item(ACTION_FLUSH, 24'hffffff, 1'b1);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 80;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct = 33;
        end
      endcase
      phase_start = useful_items;
      while (useful_items - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0: w_raw = $urandom_range(0, 2);
          1, 2: w_raw = $urandom_range(11, 20);
          default: w_raw = $urandom_range(3, 10);
        endcase
        h_raw = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        configure(w_raw, h_raw);
        repeat ($urandom_range(1, 3)) queue_run();
        settle();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("tb: %0d transactions sent over %0d frame sizes, %0d output pixels checked",
             useful_items, settings, results_seen);
    $display("tb: frames from 3x3 to 20x6 with clamped sizes, in idle and stall phases");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rbf_pkg.sv
sv/rgb_box_filter_3x3.sv
sv/rbf_checker.sv
bench/tb.sv
